// ===== rtl/dtq_pkg.sv =====
// Package for the deadline timer queue: sizes, result codes and the beat types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package dtq_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 8;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int FQ_DEPTH    = 2;
	localparam int FQ_AW       = $clog2(FQ_DEPTH);

	localparam logic [1:0] KIND_ELAPSED = 2'd0;
	localparam logic [1:0] KIND_ARMED   = 2'd1;
	localparam logic [1:0] KIND_DROPPED = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [63:0] timer_deadline;
		logic [7:0]  timer_id;
		logic [63:0] current_time;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  elapsed_id;
		logic [63:0] arm_deadline;
		logic [4:0]  active_count;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic                is_alarm;
		logic [63:0]         deadline;
		logic [ID_WIDTH-1:0] id;
		logic [63:0]         now;
	} job_t;

	typedef struct packed {
		logic                ins;
		logic                pop;
		logic [63:0]         deadline;
		logic [ID_WIDTH-1:0] id;
	} cell_ctl_t;

	typedef struct packed {
		logic [63:0]         head_deadline;
		logic [ID_WIDTH-1:0] head_id;
		logic [CNT_W-1:0]    count;
	} cell_sts_t;
endpackage
`default_nettype wire

// ===== rtl/deadline_timer_queue_core.sv =====
// Top level of the deadline timer queue: front queue, back-end sequencer,
// sorted cell chain and output register. Depends on dtq_pkg, dtq_front, dtq_cells.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req  (dtq_pkg::req_t)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp  (dtq_pkg::rsp_t)
//
// An item leaves the front queue in S_IDLE; an install then inserts in S_INS (or
// reports a drop when the cells are full), and S_SCAN gives a result beat per elapsed
// timer (each a head pop of the cells), then an armed beat while timers remain.
// An alarm on an empty store gives no result beat.
// Reset clears the fill count, the front queue and the sequencer; no sweep.
// A stalled result holds the sequencer; the front queue keeps taking beats until full.
`default_nettype none
module deadline_timer_queue_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire dtq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output dtq_pkg::rsp_t      rsp
);
	import dtq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_INS  = 3'b010,
		S_SCAN = 3'b100
	} state_t;

	state_t    state_q;
	job_t      job_q, fq_job;
	logic      fq_valid, fq_take;
	cell_ctl_t ctl;
	cell_sts_t sts;
	logic      out_free, emit;
	rsp_t      nxt_rsp;
	state_t    nxt_state;

	dtq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.job_valid (fq_valid),
		.job_take  (fq_take),
		.job       (fq_job)
	);

	dtq_cells u_cells (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts)
	);

	assign out_free = !rsp_valid || !rsp_stall;
	assign fq_take  = (state_q == S_IDLE);

	always_comb begin
		nxt_state        = state_q;
		emit             = 1'b0;
		ctl.ins          = 1'b0;
		ctl.pop          = 1'b0;
		ctl.deadline     = job_q.deadline;
		ctl.id           = job_q.id;
		nxt_rsp          = '0;
		case (state_q)
			S_IDLE: begin
				if (fq_valid) begin
					nxt_state = fq_job.is_alarm ? S_SCAN : S_INS;
				end
			end
			S_INS: begin
				if (sts.count == CNT_W'(QUEUE_DEPTH)) begin
					nxt_rsp.result_kind  = KIND_DROPPED;
					nxt_rsp.elapsed_id   = 8'(job_q.id);
					nxt_rsp.active_count = 5'(sts.count);
					if (out_free) begin
						emit      = 1'b1;
						nxt_state = S_SCAN;
					end
				end else begin
					ctl.ins   = 1'b1;
					nxt_state = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.count == '0) begin
					nxt_state = S_IDLE;
				end else if (sts.head_deadline <= job_q.now) begin
					nxt_rsp.result_kind  = KIND_ELAPSED;
					nxt_rsp.elapsed_id   = 8'(sts.head_id);
					nxt_rsp.active_count = 5'(sts.count - 1'b1);
					nxt_rsp.last         = (sts.count == CNT_W'(1));
					if (out_free) begin
						emit    = 1'b1;
						ctl.pop = 1'b1;
						if (sts.count == CNT_W'(1)) begin
							nxt_state = S_IDLE;
						end
					end
				end else begin
					nxt_rsp.result_kind  = KIND_ARMED;
					nxt_rsp.elapsed_id   = 8'(sts.head_id);
					nxt_rsp.arm_deadline = sts.head_deadline;
					nxt_rsp.active_count = 5'(sts.count);
					nxt_rsp.last         = 1'b1;
					if (out_free) begin
						emit      = 1'b1;
						nxt_state = S_IDLE;
					end
				end
			end
			default: nxt_state = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fq_take && fq_valid) begin
			job_q <= fq_job;
		end
		if (emit) begin
			rsp <= nxt_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= nxt_state;
			if (emit) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= CNT_W'(QUEUE_DEPTH))
		else $error("pending count above depth");
	a_armed_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == KIND_ARMED |-> rsp.active_count != '0)
		else $error("armed result with empty store");
	a_elapsed_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == KIND_ELAPSED && rsp.last |-> rsp.active_count == '0)
		else $error("final elapsed result with timers left");
	a_dropped_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == KIND_DROPPED |-> !rsp.last)
		else $error("dropped result marked final");
	a_no_cell_op_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !ctl.ins && !ctl.pop)
		else $error("cell update outside an item");
endmodule
`default_nettype wire

// ===== rtl/dtq_front.sv =====
// Front end: accepts request beats, classifies them into jobs and queues them.
// Depends on dtq_pkg.
`default_nettype none
module dtq_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire dtq_pkg::req_t req,
	output logic               job_valid,
	input  wire logic          job_take,
	output dtq_pkg::job_t      job
);
	import dtq_pkg::*;

	job_t             mem_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FQ_AW:0]   cnt_q;
	logic             wr, rd;
	job_t             new_job;

	assign req_stall = (cnt_q == (FQ_AW+1)'(FQ_DEPTH));
	assign wr        = req_valid && !req_stall;
	assign job_valid = (cnt_q != '0);
	assign rd        = job_take && job_valid;
	assign job       = mem_q[rd_ptr_q];

	always_comb begin
		new_job.is_alarm = req.cmd;
		new_job.deadline = req.timer_deadline;
		new_job.id       = req.timer_id[ID_WIDTH-1:0];
		new_job.now      = req.current_time;
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (FQ_AW+1)'(wr) - (FQ_AW+1)'(rd);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/dtq_cells.sv =====
// Sorted cell chain holding the pending timers, earliest deadline in cell 0.
// One insert or one head pop per cycle. Depends on dtq_pkg.
`default_nettype none
module dtq_cells (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dtq_pkg::cell_ctl_t ctl,
	output dtq_pkg::cell_sts_t      sts
);
	import dtq_pkg::*;

	logic [63:0]         dl_q [QUEUE_DEPTH];
	logic [ID_WIDTH-1:0] id_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]    count_q;
	logic [QUEUE_DEPTH-1:0] gt;
	logic [QUEUE_DEPTH-1:0] at_end;

	// A cell moves up when its deadline is strictly later, so equal deadlines
	// keep arrival order.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			gt[i]     = (CNT_W'(i) < count_q) && (dl_q[i] > ctl.deadline);
			at_end[i] = (CNT_W'(i) == count_q);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (ctl.ins) begin
				if (i > 0 && gt[(i > 0) ? i-1 : 0]) begin
					dl_q[i] <= dl_q[(i > 0) ? i-1 : 0];
					id_q[i] <= id_q[(i > 0) ? i-1 : 0];
				end else if (gt[i] || at_end[i]) begin
					dl_q[i] <= ctl.deadline;
					id_q[i] <= ctl.id;
				end
			end else if (ctl.pop && i < QUEUE_DEPTH-1) begin
				dl_q[i] <= dl_q[(i < QUEUE_DEPTH-1) ? i+1 : i];
				id_q[i] <= id_q[(i < QUEUE_DEPTH-1) ? i+1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + 1'b1;
		end else if (ctl.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	assign sts.head_deadline = dl_q[0];
	assign sts.head_id       = id_q[0];
	assign sts.count         = count_q;
endmodule
`default_nettype wire
